FILE: rtl/jef_pkg.sv
package jef_pkg;

    // defaults for the top level parameters
    localparam int MAX_LINE_DEF   = 256;
    localparam int COORD_BITS_DEF = 16;

    // field and register widths
    localparam int FIELD_W   = 16;
    localparam int INDEX_W   = 20;
    localparam int FW_W      = 9;
    localparam int FH_W      = 13;
    localparam int ROW_W     = 12;
    localparam int THR_W     = 16;
    localparam int CFG_IDX_W = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COS2_THR     = 2'd2;

    // register reset values
    localparam logic [FW_W-1:0]  FRAME_WIDTH_RST  = 9'd176;
    localparam logic [FH_W-1:0]  FRAME_HEIGHT_RST = 13'd144;
    localparam logic [THR_W-1:0] COS2_THR_RST     = 16'd63560;

    localparam int MIN_DIM      = 3;
    localparam int HEIGHT_LIMIT = 4096;

    // register stages inside one neighbor test lane
    localparam int LANE_LAT = 7;

endpackage

FILE: rtl/jef_ram.sv
module jef_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/jef_lane.sv
// One neighbor test: (v.d)^2 * 2^16 > thr * |v|^2 * |d|^2, d = v - n.
// Wide products are split into partial products of at most ~25 bits.
module jef_lane #(
    parameter int COORD_BITS = jef_pkg::COORD_BITS_DEF
) (
    input  logic                      aclk,
    input  logic                      en,
    input  logic [3*COORD_BITS-1:0]   v_pt,
    input  logic [3*COORD_BITS-1:0]   n_pt,
    input  logic [jef_pkg::THR_W-1:0] thr,
    output logic                      hit
);

    localparam int C    = COORD_BITS;
    localparam int TW   = jef_pkg::THR_W;
    localparam int DW   = C + 1;
    localparam int PW   = 2 * C + 1;
    localparam int QSW  = 2 * C + 2;
    localparam int SW   = 2 * C + 2;
    localparam int VVW  = 2 * C;
    localparam int DDW  = 2 * C + 2;
    localparam int ADW  = 2 * C + 1;
    localparam int HA   = (ADW + 1) / 2;
    localparam int HV   = (VVW + 1) / 2;
    localparam int HD   = (DDW + 1) / 2;
    localparam int SQW  = 2 * ADW;
    localparam int PVW  = VVW + DDW;
    localparam int QW   = (PVW + 3) / 4;
    localparam int LHW  = SQW + TW;
    localparam int RHW  = 4 * QW + TW;
    localparam int CMW  = (LHW > RHW) ? LHW : RHW;

    // stage A: difference
    logic signed [C-1:0]  a_v_reg [3];
    logic signed [DW-1:0] a_d_reg [3];
    // stage B: products
    logic signed [PW-1:0]  b_vd_reg [3];
    logic signed [QSW-1:0] b_vv_reg [3];
    logic signed [QSW-1:0] b_dd_reg [3];
    // stage C: sums
    logic signed [SW-1:0] c_dot_reg;
    logic [VVW-1:0]       c_vv_reg;
    logic [DDW-1:0]       c_dd_reg;
    // stage D: partial products
    logic [2*(ADW-HA)-1:0]  d_hh_reg;
    logic [ADW-1:0]         d_hl_reg;
    logic [2*HA-1:0]        d_ll_reg;
    logic [VVW-HV+DDW-HD-1:0] d_vhdh_reg;
    logic [VVW-HV+HD-1:0]   d_vhdl_reg;
    logic [HV+DDW-HD-1:0]   d_vldh_reg;
    logic [HV+HD-1:0]       d_vldl_reg;
    logic                   d_zero_reg;
    // stage E: full products
    logic [SQW-1:0] e_sq_reg;
    logic [PVW-1:0] e_pv_reg;
    logic           e_zero_reg;
    // stage F: threshold partial products
    logic [QW+TW-1:0] f_pt_reg [4];
    logic [SQW-1:0]   f_sq_reg;
    logic             f_zero_reg;
    // stage G
    logic g_hit_reg;

    logic signed [SW-1:0] dot_next;
    logic signed [QSW+1:0] vv_sum, dd_sum;
    logic signed [SW-1:0]  ad_s;
    logic [ADW-1:0]        ad;
    logic [SQW-1:0]        sq_next;
    logic [PVW-1:0]        pv_next;
    logic [4*QW-1:0]       pv_pad;
    logic [CMW-1:0]        lhs, rhs;

    always_comb begin
        dot_next = SW'(b_vd_reg[0]) + SW'(b_vd_reg[1]) + SW'(b_vd_reg[2]);
        vv_sum = (QSW+2)'(b_vv_reg[0]) + (QSW+2)'(b_vv_reg[1]) + (QSW+2)'(b_vv_reg[2]);
        dd_sum = (QSW+2)'(b_dd_reg[0]) + (QSW+2)'(b_dd_reg[1]) + (QSW+2)'(b_dd_reg[2]);
        ad_s = (c_dot_reg < 0) ? -c_dot_reg : c_dot_reg;
        ad = ad_s[ADW-1:0];
        sq_next = (SQW'(d_hh_reg) << (2 * HA)) + (SQW'(d_hl_reg) << (HA + 1))
                + SQW'(d_ll_reg);
        pv_next = (PVW'(d_vhdh_reg) << (HV + HD)) + (PVW'(d_vhdl_reg) << HV)
                + (PVW'(d_vldh_reg) << HD) + PVW'(d_vldl_reg);
        pv_pad = (4*QW)'(e_pv_reg);
        lhs = CMW'(f_sq_reg) << TW;
        rhs = CMW'(f_pt_reg[0]) + (CMW'(f_pt_reg[1]) << QW)
            + (CMW'(f_pt_reg[2]) << (2 * QW)) + (CMW'(f_pt_reg[3]) << (3 * QW));
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                a_v_reg[i] <= v_pt[i*C +: C];
                a_d_reg[i] <= DW'($signed(v_pt[i*C +: C])) - DW'($signed(n_pt[i*C +: C]));
                b_vd_reg[i] <= PW'(a_v_reg[i] * a_d_reg[i]);
                b_vv_reg[i] <= QSW'(a_v_reg[i] * a_v_reg[i]);
                b_dd_reg[i] <= QSW'(a_d_reg[i] * a_d_reg[i]);
            end
            c_dot_reg <= dot_next;
            c_vv_reg  <= vv_sum[VVW-1:0];
            c_dd_reg  <= dd_sum[DDW-1:0];

            d_hh_reg   <= ad[ADW-1:HA] * ad[ADW-1:HA];
            d_hl_reg   <= ad[ADW-1:HA] * ad[HA-1:0];
            d_ll_reg   <= ad[HA-1:0] * ad[HA-1:0];
            d_vhdh_reg <= c_vv_reg[VVW-1:HV] * c_dd_reg[DDW-1:HD];
            d_vhdl_reg <= c_vv_reg[VVW-1:HV] * c_dd_reg[HD-1:0];
            d_vldh_reg <= c_vv_reg[HV-1:0] * c_dd_reg[DDW-1:HD];
            d_vldl_reg <= c_vv_reg[HV-1:0] * c_dd_reg[HD-1:0];
            d_zero_reg <= (c_vv_reg == '0) || (c_dd_reg == '0);

            e_sq_reg   <= sq_next;
            e_pv_reg   <= pv_next;
            e_zero_reg <= d_zero_reg;

            for (int k = 0; k < 4; k++) begin
                f_pt_reg[k] <= pv_pad[k*QW +: QW] * thr;
            end
            f_sq_reg   <= e_sq_reg;
            f_zero_reg <= e_zero_reg;

            g_hit_reg <= !f_zero_reg && (lhs > rhs);
        end
    end

    assign hit = g_hit_reg;

endmodule

FILE: rtl/jump_edge_filter_3x3.sv
// Jump edge filter over a 3x3 window of an organized depth image.
//
// Input words (s_*): one 3D point per word in raster order; s_tuser marks
// the first point of a new image. Result words (m_*): the raster index of
// a point whose ray and step to some neighbor are nearly parallel, i.e.
// (v.d)^2 * 2^16 > cos2_threshold * |v|^2 * |d|^2. Border points and zero
// vectors never produce a word. Results come out in input order.
// Config channel (cfg_*): always ready; write only while the block is idle.
//
// Throughput: one point per cycle when not stalled. A result word reaches m_*
// from the input word that completes its window through the line store
// read (loaded on the accept edge), window, seven lane stages, output reg.
// The result index refers to the window centre, one row and one column
// behind the newest point.
//
// Reset (aresetn low, synchronous) clears counters, pipeline valids, line
// store valid bits and restores register defaults. When m_tready is low
// with a result waiting, the whole pipeline holds and s_tready drops; no
// word is lost or repeated.
module jump_edge_filter_3x3 #(
    parameter int MAX_LINE   = jef_pkg::MAX_LINE_DEF,
    parameter int COORD_BITS = jef_pkg::COORD_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [3*jef_pkg::FIELD_W-1:0] s_tdata,   // x_coord, y_coord, z_coord
    input  logic                          s_tuser,   // frame_start
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [23:0]                   m_tdata,   // removed_index, zero pad
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [jef_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [jef_pkg::THR_W-1:0]     cfg_data
);

    localparam int C    = COORD_BITS;
    localparam int PTW  = 3 * C;
    localparam int CW   = $clog2(MAX_LINE);
    localparam int WCMP = (CW + 1 > jef_pkg::FW_W) ? CW + 1 : jef_pkg::FW_W;
    localparam int IW   = jef_pkg::INDEX_W;
    localparam int RW   = jef_pkg::ROW_W;
    localparam int HW   = jef_pkg::FH_W;
    localparam int LAT  = jef_pkg::LANE_LAT;
    localparam int FWID = jef_pkg::FIELD_W;

    // config registers
    logic [jef_pkg::FW_W-1:0]  fw_reg;
    logic [HW-1:0]             fh_reg;
    logic [jef_pkg::THR_W-1:0] thr_reg;

    // raster counters
    logic [IW-1:0] pc_reg;
    logic [CW-1:0] col_reg;
    logic [RW-1:0] row_reg;

    logic adv;
    logic acc;

    assign adv       = !m_tvalid || m_tready;
    assign s_tready  = adv;
    assign acc       = s_tvalid && adv;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fw_reg  <= jef_pkg::FRAME_WIDTH_RST;
            fh_reg  <= jef_pkg::FRAME_HEIGHT_RST;
            thr_reg <= jef_pkg::COS2_THR_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                jef_pkg::REG_FRAME_WIDTH:  fw_reg  <= cfg_data[jef_pkg::FW_W-1:0];
                jef_pkg::REG_FRAME_HEIGHT: fh_reg  <= cfg_data[HW-1:0];
                jef_pkg::REG_COS2_THR:     thr_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // effective (clamped) frame size
    logic [WCMP-1:0] w_eff;
    logic [HW-1:0]   h_eff;

    always_comb begin
        if (WCMP'(fw_reg) < WCMP'(jef_pkg::MIN_DIM)) begin
            w_eff = WCMP'(jef_pkg::MIN_DIM);
        end else if (WCMP'(fw_reg) > WCMP'(MAX_LINE)) begin
            w_eff = WCMP'(MAX_LINE);
        end else begin
            w_eff = WCMP'(fw_reg);
        end
        if (fh_reg < HW'(jef_pkg::MIN_DIM)) begin
            h_eff = HW'(jef_pkg::MIN_DIM);
        end else if (fh_reg > HW'(jef_pkg::HEIGHT_LIMIT)) begin
            h_eff = HW'(jef_pkg::HEIGHT_LIMIT);
        end else begin
            h_eff = fh_reg;
        end
    end

    // stage 0: counters for the incoming word
    logic [IW-1:0] pc0, pc_next;
    logic [CW-1:0] col0, col_next;
    logic [RW-1:0] row0, row_next;
    logic          int0;
    logic [IW-1:0] idx0;
    logic [PTW-1:0] p0;
    logic [31:0]   fx, fy, fz;

    always_comb begin
        pc0  = s_tuser ? '0 : pc_reg;
        col0 = s_tuser ? '0 : col_reg;
        row0 = s_tuser ? '0 : row_reg;
        int0 = (col0 >= CW'(2)) && (row0 >= RW'(2));
        idx0 = pc0 - IW'(w_eff) - IW'(1);
        if (WCMP'(col0) >= w_eff - WCMP'(1)) begin
            col_next = '0;
            if (HW'(row0) >= h_eff - HW'(1)) begin
                row_next = '0;
                pc_next  = '0;
            end else begin
                row_next = row0 + RW'(1);
                pc_next  = pc0 + IW'(1);
            end
        end else begin
            col_next = col0 + CW'(1);
            row_next = row0;
            pc_next  = pc0 + IW'(1);
        end
        // coordinates taken as COORD_BITS-bit raw fields
        fx = 32'(s_tdata[0*FWID +: FWID]);
        fy = 32'(s_tdata[1*FWID +: FWID]);
        fz = 32'(s_tdata[2*FWID +: FWID]);
        p0 = {fz[C-1:0], fy[C-1:0], fx[C-1:0]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg  <= '0;
            col_reg <= '0;
            row_reg <= '0;
        end else if (acc) begin
            pc_reg  <= pc_next;
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // line stores: one RAM, entry = {older row, newer row}
    logic [MAX_LINE-1:0] lvalid_reg;
    logic                s1_valid_reg;
    logic                s1_int_reg;
    logic [IW-1:0]       s1_idx_reg;
    logic [CW-1:0]       s1_col_reg;
    logic [PTW-1:0]      s1_p_reg;
    logic                s1_byp_reg;
    logic [2*PTW-1:0]    s1_bypd_reg;
    logic                s1_lv_reg;
    logic [2*PTW-1:0]    ram_rd;
    logic [2*PTW-1:0]    line1;
    logic                wr_en;
    logic [2*PTW-1:0]    wr_data;

    assign line1   = s1_byp_reg ? s1_bypd_reg : (s1_lv_reg ? ram_rd : '0);
    assign wr_en   = adv && s1_valid_reg;
    assign wr_data = {line1[PTW-1:0], s1_p_reg};

    jef_ram #(
        .WIDTH(2 * PTW),
        .DEPTH(MAX_LINE)
    ) u_line_ram (
        .aclk (aclk),
        .we   (wr_en),
        .waddr(s1_col_reg),
        .wdata(wr_data),
        .re   (adv),
        .raddr(col0),
        .rdata(ram_rd)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lvalid_reg   <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                lvalid_reg[s1_col_reg] <= 1'b1;
            end
            if (adv) begin
                s1_valid_reg <= s_tvalid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_int_reg  <= int0;
            s1_idx_reg  <= idx0;
            s1_col_reg  <= col0;
            s1_p_reg    <= p0;
            // same entry written this cycle: forward the new line data
            s1_byp_reg  <= wr_en && (s1_col_reg == col0);
            s1_bypd_reg <= wr_data;
            s1_lv_reg   <= lvalid_reg[col0];
        end
    end

    // stage 2: 3x3 window, newest column right
    logic [PTW-1:0] win_reg [3][3];
    logic           s2_valid_reg;
    logic [IW-1:0]  s2_idx_reg;

    always_ff @(posedge aclk) begin
        if (adv && s1_valid_reg) begin
            for (int r = 0; r < 3; r++) begin
                win_reg[r][0] <= win_reg[r][1];
                win_reg[r][1] <= win_reg[r][2];
            end
            win_reg[0][2] <= line1[2*PTW-1:PTW];
            win_reg[1][2] <= line1[PTW-1:0];
            win_reg[2][2] <= s1_p_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (adv) begin
            s2_valid_reg <= s1_valid_reg && s1_int_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s2_idx_reg <= s1_idx_reg;
        end
    end

    // eight neighbor lanes
    logic [8:0] hit_vec;

    assign hit_vec[4] = 1'b0;

    for (genvar k = 0; k < 9; k++) begin : g_lane
        if (k != 4) begin : g_nb
            jef_lane #(
                .COORD_BITS(COORD_BITS)
            ) u_lane (
                .aclk (aclk),
                .en   (adv),
                .v_pt (win_reg[1][1]),
                .n_pt (win_reg[k / 3][k % 3]),
                .thr  (thr_reg),
                .hit  (hit_vec[k])
            );
        end
    end

    // valid and index travel beside the lanes
    logic          pv_reg [LAT];
    logic [IW-1:0] pidx_reg [LAT];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < LAT; i++) begin
                pv_reg[i] <= 1'b0;
            end
        end else if (adv) begin
            pv_reg[0] <= s2_valid_reg;
            for (int i = 1; i < LAT; i++) begin
                pv_reg[i] <= pv_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            pidx_reg[0] <= s2_idx_reg;
            for (int i = 1; i < LAT; i++) begin
                pidx_reg[i] <= pidx_reg[i-1];
            end
        end
    end

    // output register
    logic          m_valid_reg;
    logic [IW-1:0] m_idx_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= pv_reg[LAT-1] && (|hit_vec);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_idx_reg <= pidx_reg[LAT-1];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0, m_idx_reg};

endmodule
